### rtl/three_axis_pid_with_yaw_hold_macros.svh
// assertion macros for the three-axis pid block
// expect clk and rst in the scope of the module that uses them
`ifndef THREE_AXIS_PID_WITH_YAW_HOLD_MACROS_SVH
`define THREE_AXIS_PID_WITH_YAW_HOLD_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TPID_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TPID_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tpid_pkg.sv
// shared types and constants for the three-axis pid block
// used by the controller, the datapath and the top level
package tpid_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 31;
  localparam int AXIS_W     = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_CLAMP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_TIME   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_RATE   = 3'd5;

  localparam logic [23:0] RST_GAIN_PROP   = 24'd65536;
  localparam logic [23:0] RST_GAIN_INTEG  = 24'd655;
  localparam logic [23:0] RST_GAIN_DERIV  = 24'd3277;
  localparam logic [30:0] RST_INTEG_CLAMP = 31'd655360;
  localparam logic [15:0] RST_STEP_TIME   = 16'd1311;
  localparam logic [15:0] RST_STEP_RATE   = 16'd12800;

  // pi and 2*pi in q5.13
  localparam logic signed [17:0] HEAD_PI     = 18'sd25736;
  localparam logic signed [17:0] HEAD_TWO_PI = 18'sd51472;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ERR,
    OP_DIFF,
    OP_YAW,
    OP_LOAD,
    OP_MUL,
    OP_SUM,
    OP_POST,
    OP_CLAMP,
    OP_OUTAX,
    OP_DONE
  } op_t;

  // which product the shared multiplier is working on
  typedef enum logic [2:0] {
    T_DT,
    T_RATE,
    T_KP,
    T_KI,
    T_KD,
    T_YAW
  } term_t;

  typedef struct packed {
    op_t               op;
    term_t             term;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } status_t;

endpackage

### rtl/tpid_if.sv
// valid/ready channels of the three-axis pid block
// input channel carries one sample, output channel one command word
interface tpid_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic signed [31:0] goal_z;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [31:0] meas_z;
  logic signed [15:0] goal_heading;
  logic signed [15:0] meas_heading;

  modport source (
    output valid, goal_x, goal_y, goal_z, meas_x, meas_y, meas_z,
           goal_heading, meas_heading,
    input  ready
  );
  modport sink (
    input  valid, goal_x, goal_y, goal_z, meas_x, meas_y, meas_z,
           goal_heading, meas_heading,
    output ready
  );
endinterface

interface tpid_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] turn_rate;

  modport source (
    output valid, vel_x, vel_y, vel_z, turn_rate,
    input  ready
  );
  modport sink (
    input  valid, vel_x, vel_y, vel_z, turn_rate,
    output ready
  );
endinterface

### rtl/tpid_ctrl.sv
// sequencer of the three-axis pid block
// walks each axis through its five products, then the yaw term; uses tpid_pkg
module tpid_ctrl
  import tpid_pkg::*;
#(
  parameter int AXES = 3
) (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_DIFF,
    S_YAW,
    S_LOAD,
    S_MUL,
    S_SUM,
    S_POST,
    S_CLAMP,
    S_OUTAX,
    S_DONE
  } state_t;

  state_t            state;
  term_t             term;
  logic [AXIS_W-1:0] axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= T_DT;
      axis  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (status.in_valid) begin
            state <= S_ERR;
            axis  <= '0;
          end
        end
        S_ERR: state <= S_DIFF;
        S_DIFF: begin
          term  <= T_DT;
          state <= S_LOAD;
        end
        S_LOAD: state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_POST;
        S_POST: begin
          case (term)
            T_DT: state <= S_CLAMP;
            T_RATE: begin
              term  <= T_KP;
              state <= S_LOAD;
            end
            T_KP: begin
              term  <= T_KI;
              state <= S_LOAD;
            end
            T_KI: begin
              term  <= T_KD;
              state <= S_LOAD;
            end
            T_KD:   state <= S_OUTAX;
            T_YAW:  state <= S_DONE;
            default: state <= S_IDLE;
          endcase
        end
        S_CLAMP: begin
          term  <= T_RATE;
          state <= S_LOAD;
        end
        S_OUTAX: begin
          if (axis == LAST_AXIS) begin
            state <= S_YAW;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_ERR;
          end
        end
        S_YAW: begin
          term  <= T_YAW;
          state <= S_LOAD;
        end
        S_DONE: begin
          // hold the word until the output register is free
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.term = term;
    cmd.axis = axis;
    case (state)
      S_IDLE:  cmd.op = OP_IDLE;
      S_ERR:   cmd.op = OP_ERR;
      S_DIFF:  cmd.op = OP_DIFF;
      S_YAW:   cmd.op = OP_YAW;
      S_LOAD:  cmd.op = OP_LOAD;
      S_MUL:   cmd.op = OP_MUL;
      S_SUM:   cmd.op = OP_SUM;
      S_POST:  cmd.op = OP_POST;
      S_CLAMP: cmd.op = OP_CLAMP;
      S_OUTAX: cmd.op = OP_OUTAX;
      S_DONE:  cmd.op = OP_DONE;
      default: cmd.op = OP_IDLE;
    endcase
  end

endmodule

### rtl/tpid_datapath.sv
// datapath of the three-axis pid block: config registers, axis state,
// one shared split multiplier and the output register; uses tpid_pkg and tpid_if
module tpid_datapath
  import tpid_pkg::*;
#(
  parameter int AXES      = 3,
  parameter int POS_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               status,
  tpid_in_if.sink               in_ch,
  tpid_out_if.source            out_ch
);

  localparam int PW   = POS_WIDTH;
  localparam int AW   = PW + 20;
  localparam int MAGW = (PW + 1 > 25) ? PW + 1 : 25;
  localparam int HW   = MAGW - 24;
  localparam int PHW  = HW + 24;
  localparam int SW   = HW + 41;
  localparam int MW   = PW + 12;
  localparam int AXW  = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic signed [AW-1:0] SAT_HI = {{(AW - PW + 1){1'b0}}, {(PW - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW - PW + 1){1'b1}}, {(PW - 1){1'b0}}};

  function automatic logic signed [PW-1:0] sat_pw(input logic signed [AW-1:0] v);
    if (v > SAT_HI) return SAT_HI[PW-1:0];
    if (v < SAT_LO) return SAT_LO[PW-1:0];
    return v[PW-1:0];
  endfunction

  // sign-extend or cut to the 32-bit result field
  function automatic logic [31:0] to_field(input logic signed [PW-1:0] v);
    logic signed [AW-1:0] t;
    t = AW'(v);
    return t[31:0];
  endfunction

  logic [23:0] gain_prop, gain_integ, gain_deriv;
  logic [30:0] integ_clamp;
  logic [15:0] step_time, step_rate;

  logic signed [31:0] goal [3];
  logic signed [31:0] meas [3];
  logic signed [15:0] goal_head, meas_head;

  logic signed [PW-1:0] integ_sum [AXES];
  logic signed [PW-1:0] last_err  [AXES];

  logic signed [PW-1:0] err, integ_w, deriv;
  logic signed [PW:0]   diff;
  logic signed [16:0]   yaw_d;
  logic                 neg;
  logic [MAGW-1:0]      mag;
  logic [PHW-1:0]       ph;
  logic [47:0]          pl;
  logic [MW-1:0]        mval;
  logic signed [AW-1:0] acc;
  logic [31:0]          res_vel [AXES];
  logic [31:0]          res_turn;
  logic [31:0]          vel_next [3];

  logic [31:0] out_vel [3];
  logic [31:0] out_turn;
  logic        out_valid;
  logic        out_free;

  logic [AXW-1:0]       ax;
  logic signed [AW-1:0] err_full;
  logic signed [17:0]   head_diff, head_wrap;
  logic signed [PW:0]   opnd, opnd_abs;
  logic [23:0]          gain;
  logic [SW-1:0]        sum_full;
  logic signed [AW-1:0] mext, post_base, post_val;
  logic signed [AW-1:0] lim_pos, lim_neg, integ_ext, clamp_val;

  assign ax = cmd.axis[AXW-1:0];

  assign out_free        = !out_valid || out_ch.ready;
  assign status.out_free = out_free;
  assign status.in_valid = in_ch.valid;
  assign in_ch.ready     = (cmd.op == OP_IDLE);

  assign out_ch.valid     = out_valid;
  assign out_ch.vel_x     = out_vel[0];
  assign out_ch.vel_y     = out_vel[1];
  assign out_ch.vel_z     = out_vel[2];
  assign out_ch.turn_rate = out_turn;

  // axes beyond the configured count report zero
  for (genvar g = 0; g < 3; g++) begin : g_vel
    if (g < AXES) begin : g_used
      assign vel_next[g] = res_vel[g];
    end else begin : g_unused
      assign vel_next[g] = '0;
    end
  end

  always_comb begin
    err_full = AW'(goal[cmd.axis]) - AW'(meas[cmd.axis]);

    // yaw error wrapped once into [-pi, pi]
    head_diff = 18'(goal_head) - 18'(meas_head);
    if (head_diff > HEAD_PI) begin
      head_wrap = head_diff - HEAD_TWO_PI;
    end else if (head_diff < -HEAD_PI) begin
      head_wrap = head_diff + HEAD_TWO_PI;
    end else begin
      head_wrap = head_diff;
    end

    case (cmd.term)
      T_DT: begin
        opnd = (PW + 1)'(err);
        gain = {8'd0, step_time};
      end
      T_RATE: begin
        opnd = diff;
        gain = {8'd0, step_rate};
      end
      T_KP: begin
        opnd = (PW + 1)'(err);
        gain = gain_prop;
      end
      T_KI: begin
        opnd = (PW + 1)'(integ_w);
        gain = gain_integ;
      end
      T_KD: begin
        opnd = (PW + 1)'(deriv);
        gain = gain_deriv;
      end
      T_YAW: begin
        opnd = (PW + 1)'(yaw_d);
        gain = gain_prop;
      end
      default: begin
        opnd = '0;
        gain = '0;
      end
    endcase
    opnd_abs = opnd[PW] ? -opnd : opnd;

    // recombine the two partial products, magnitude truncated
    case (cmd.term)
      T_RATE:  sum_full = (SW'(ph) << 16) + SW'(pl >> 8);
      T_YAW:   sum_full = (SW'(ph) << 11) + SW'(pl >> 13);
      default: sum_full = (SW'(ph) << 8) + SW'(pl >> 16);
    endcase

    mext = AW'(mval);
    case (cmd.term)
      T_DT:       post_base = AW'(integ_sum[ax]);
      T_KI, T_KD: post_base = acc;
      default:    post_base = '0;
    endcase
    post_val = neg ? post_base - mext : post_base + mext;

    lim_pos   = AW'(integ_clamp);
    lim_neg   = -lim_pos;
    integ_ext = AW'(integ_w);
    if (integ_ext > lim_pos) begin
      clamp_val = lim_pos;
    end else if (integ_ext < lim_neg) begin
      clamp_val = lim_neg;
    end else begin
      clamp_val = integ_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop   <= RST_GAIN_PROP;
      gain_integ  <= RST_GAIN_INTEG;
      gain_deriv  <= RST_GAIN_DERIV;
      integ_clamp <= RST_INTEG_CLAMP;
      step_time   <= RST_STEP_TIME;
      step_rate   <= RST_STEP_RATE;
      for (int i = 0; i < AXES; i++) begin
        integ_sum[i] <= '0;
        last_err[i]  <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GAIN_PROP:   gain_prop   <= cfg_data[23:0];
          REG_GAIN_INTEG:  gain_integ  <= cfg_data[23:0];
          REG_GAIN_DERIV:  gain_deriv  <= cfg_data[23:0];
          REG_INTEG_CLAMP: integ_clamp <= cfg_data[30:0];
          REG_STEP_TIME:   step_time   <= cfg_data[15:0];
          REG_STEP_RATE:   step_rate   <= cfg_data[15:0];
          default: ;
        endcase
      end

      // a finished word loads when the register is empty or as the previous one leaves
      if (cmd.op == OP_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (cmd.op)
        OP_IDLE: begin
          if (in_ch.valid) begin
            goal[0]   <= in_ch.goal_x;
            goal[1]   <= in_ch.goal_y;
            goal[2]   <= in_ch.goal_z;
            meas[0]   <= in_ch.meas_x;
            meas[1]   <= in_ch.meas_y;
            meas[2]   <= in_ch.meas_z;
            goal_head <= in_ch.goal_heading;
            meas_head <= in_ch.meas_heading;
          end
        end
        OP_ERR:  err   <= sat_pw(err_full);
        OP_DIFF: diff  <= (PW + 1)'(err) - (PW + 1)'(last_err[ax]);
        OP_YAW:  yaw_d <= head_wrap[16:0];
        OP_LOAD: begin
          neg <= opnd[PW];
          mag <= MAGW'($unsigned(opnd_abs));
        end
        OP_MUL: begin
          ph <= PHW'(mag[MAGW-1:24]) * PHW'(gain);
          pl <= 48'(mag[23:0]) * 48'(gain);
        end
        OP_SUM: mval <= sum_full[MW-1:0];
        OP_POST: begin
          case (cmd.term)
            T_DT: integ_w <= sat_pw(post_val);
            T_RATE: begin
              deriv        <= sat_pw(post_val);
              last_err[ax] <= err;
            end
            T_KP, T_KI, T_KD: acc <= post_val;
            T_YAW: res_turn <= to_field(sat_pw(post_val));
            default: ;
          endcase
        end
        OP_CLAMP: begin
          integ_w       <= clamp_val[PW-1:0];
          integ_sum[ax] <= clamp_val[PW-1:0];
        end
        OP_OUTAX: res_vel[ax] <= to_field(sat_pw(acc));
        OP_DONE: begin
          if (out_free) begin
            out_vel  <= vel_next;
            out_turn <= res_turn;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/three_axis_pid_with_yaw_hold.sv
// Three-axis PID position controller with proportional yaw hold. A sample is
// taken when the block is idle; each axis then runs through five products
// (error times dt, error difference times 1/dt, and the P, I and D gains) on a
// single shared multiplier split into a high and a low partial product, with
// each product in a load, multiply, sum and post step, followed by the
// proportional yaw term. The next sample is taken once the finished word is in
// the output register and the block is idle again; the output register holds a
// finished word while the next sample is accepted. Configuration registers are
// written through cfg_we/cfg_addr/cfg_data; the user must write them only between
// samples for them to take effect for the next sample, as the block itself does
// not enforce it. Integral and previous-error state clear on reset.
`include "three_axis_pid_with_yaw_hold_macros.svh"

module three_axis_pid_with_yaw_hold
  import tpid_pkg::*;
#(
  parameter int AXES      = 3,
  parameter int POS_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  tpid_in_if.sink               in_ch,
  tpid_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  tpid_ctrl #(
    .AXES (AXES)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  tpid_datapath #(
    .AXES      (AXES),
    .POS_WIDTH (POS_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // a taken sample keeps the input closed while it is worked on
  `TPID_ASSERT_NEXT(a_busy_after_take, in_ch.valid && in_ch.ready, !in_ch.ready, "input still open after a word was taken")
  // a new output word only comes out of a busy cycle
  `TPID_ASSERT_SAME(a_out_from_busy, $rose(out_ch.valid), $past(!in_ch.ready), "output word appeared without work")
  // a finished word is loaded once the output register is free
  `TPID_ASSERT_NEXT(a_done_loads, cmd.op == OP_DONE && status.out_free, out_ch.valid, "finished word not loaded")

endmodule

### tb/sv/tpid_sb_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the three-axis pid testbench: sample and command word types,
// a bit-exact predictor of the controller and the queue of commands still due
// depends on tpid_pkg for register indexes, reset values and the q5.13 pi constants
package tpid_sb_pkg;
  import tpid_pkg::*;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    logic signed [15:0] goal_heading;
    logic signed [15:0] meas_heading;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] turn_rate;
  } command_t;

  class cmd_scoreboard;
    logic [23:0] gain_prop;
    logic [23:0] gain_integ;
    logic [23:0] gain_deriv;
    logic [30:0] integ_clamp;
    logic [15:0] step_time;
    logic [15:0] step_rate;
    longint      integ_sum[3];
    longint      last_err[3];
    command_t    pending_cmds[$];
    int          n_fail;

    function new();
      gain_prop   = RST_GAIN_PROP;
      gain_integ  = RST_GAIN_INTEG;
      gain_deriv  = RST_GAIN_DERIV;
      integ_clamp = RST_INTEG_CLAMP;
      step_time   = RST_STEP_TIME;
      step_rate   = RST_STEP_RATE;
      foreach (integ_sum[i]) begin
        integ_sum[i] = 0;
        last_err[i]  = 0;
      end
      n_fail = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GAIN_PROP:   gain_prop   = val[23:0];
        REG_GAIN_INTEG:  gain_integ  = val[23:0];
        REG_GAIN_DERIV:  gain_deriv  = val[23:0];
        REG_INTEG_CLAMP: integ_clamp = val[30:0];
        REG_STEP_TIME:   step_time   = val[15:0];
        REG_STEP_RATE:   step_rate   = val[15:0];
        default: ;
      endcase
    endfunction

    static function longint sat_pos(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // (v * g) >> s on the magnitude, split at bit 24 like the shared multiplier
    static function longint scale_trunc(longint v, longint unsigned g, int unsigned s);
      bit                neg;
      longint unsigned   mag;
      longint unsigned   p;
      neg = v < 0;
      mag = v;
      if (neg) mag = -mag;
      p = (((mag >> 24) * g) << (24 - s)) + (((mag & 64'hFFFFFF) * g) >> s);
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function void take_sample(sample_t s);
      longint   goal[3];
      longint   meas[3];
      longint   vel[3];
      longint   e;
      longint   integ;
      longint   deriv;
      longint   lim;
      longint   d;
      command_t c;
      goal[0] = longint'(s.goal_x);
      goal[1] = longint'(s.goal_y);
      goal[2] = longint'(s.goal_z);
      meas[0] = longint'(s.meas_x);
      meas[1] = longint'(s.meas_y);
      meas[2] = longint'(s.meas_z);
      lim = longint'(integ_clamp);
      for (int i = 0; i < 3; i++) begin
        e = sat_pos(goal[i] - meas[i]);
        integ = sat_pos(integ_sum[i] + scale_trunc(e, step_time, 16));
        if (integ > lim) integ = lim;
        if (integ < -lim) integ = -lim;
        integ_sum[i] = integ;
        deriv = sat_pos(scale_trunc(e - last_err[i], step_rate, 8));
        last_err[i] = e;
        vel[i] = sat_pos(scale_trunc(e, gain_prop, 16) + scale_trunc(integ, gain_integ, 16)
                         + scale_trunc(deriv, gain_deriv, 16));
      end
      // heading error wrapped back into [-pi, pi]
      d = longint'(s.goal_heading) - longint'(s.meas_heading);
      while (d > longint'(HEAD_PI)) d -= longint'(HEAD_TWO_PI);
      while (d < -longint'(HEAD_PI)) d += longint'(HEAD_TWO_PI);
      c.vel_x     = 32'(vel[0]);
      c.vel_y     = 32'(vel[1]);
      c.vel_z     = 32'(vel[2]);
      c.turn_rate = 32'(sat_pos(scale_trunc(d, gain_prop, 13)));
      pending_cmds.push_back(c);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        n_fail++;
      end
    endfunction

    function void check_command(command_t got);
      command_t want;
      if (pending_cmds.size() == 0) begin
        $error("command word with no sample waiting for it");
        n_fail++;
        return;
      end
      want = pending_cmds.pop_front();
      check_field("vel_x", want.vel_x, got.vel_x);
      check_field("vel_y", want.vel_y, got.vel_y);
      check_field("vel_z", want.vel_z, got.vel_z);
      check_field("turn_rate", want.turn_rate, got.turn_rate);
    endfunction
  endclass

endpackage

### tb/sv/tb_three_axis_pid_with_yaw_hold.sv
`timescale 1ns / 1ps
// top of the three-axis pid testbench: clock, reset, sample driver, command sink
// with random stalls and a long hold-off, register writes between phases
// depends on tpid_pkg, tpid_if and tpid_sb_pkg
module tb_three_axis_pid_with_yaw_hold;
  import tpid_pkg::*;
  import tpid_sb_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic signed [31:0]    POS_MAX      = 32'sh7FFFFFFF;
  localparam logic signed [31:0]    POS_MIN      = 32'sh80000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  tpid_in_if  in_ch ();
  tpid_out_if out_ch ();

  cmd_scoreboard sb = new();
  int            src_idle_pct = 26;
  int            snk_idle_pct = 81;
  bit            hold_req;
  int            hold_left;

  three_axis_pid_with_yaw_hold u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // command sink: check at the rising edge, pick ready at the falling edge
  initial begin
    command_t got;
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.vel_x     = out_ch.vel_x;
        got.vel_y     = out_ch.vel_y;
        got.vel_z     = out_ch.vel_z;
        got.turn_rate = out_ch.turn_rate;
        sb.check_command(got);
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic sample_t pack_sample(
    input logic signed [31:0] gx, gy, gz, mx, my, mz,
    input logic signed [15:0] gh, mh
  );
    sample_t s;
    s.goal_x = gx;
    s.goal_y = gy;
    s.goal_z = gz;
    s.meas_x = mx;
    s.meas_y = my;
    s.meas_z = mz;
    s.goal_heading = gh;
    s.meas_heading = mh;
    return s;
  endfunction

  function automatic logic signed [31:0] rand_goal();
    if ($urandom_range(4) == 0) return $urandom();
    return int'($urandom_range(0, 33554432)) - 16777216;
  endfunction

  // mostly a measurement tracking the goal, sometimes anywhere
  function automatic logic signed [31:0] rand_meas(logic signed [31:0] goal);
    if ($urandom_range(9) < 3) return $urandom();
    return goal + (int'($urandom_range(0, 524288)) - 262144);
  endfunction

  function automatic logic signed [15:0] rand_heading();
    if ($urandom_range(9) == 0) return 16'($urandom());
    return 16'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 1048576));
    endcase
  endfunction

  function automatic logic [15:0] rand_period();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // stop offering and let every command word come back before touching registers
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [23:0] gp, gi, gd, input logic [30:0] clamp,
                            input logic [15:0] st, sr);
    wait_drained();
    write_reg(REG_GAIN_PROP, CFG_DATA_W'(gp));
    write_reg(REG_GAIN_INTEG, CFG_DATA_W'(gi));
    write_reg(REG_GAIN_DERIV, CFG_DATA_W'(gd));
    write_reg(REG_INTEG_CLAMP, CFG_DATA_W'(clamp));
    write_reg(REG_STEP_TIME, CFG_DATA_W'(st));
    write_reg(REG_STEP_RATE, CFG_DATA_W'(sr));
  endtask

  // valid stays high between back-to-back words; returns at the accepting edge
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.goal_x       = s.goal_x;
    in_ch.goal_y       = s.goal_y;
    in_ch.goal_z       = s.goal_z;
    in_ch.meas_x       = s.meas_x;
    in_ch.meas_y       = s.meas_y;
    in_ch.meas_z       = s.meas_z;
    in_ch.goal_heading = s.goal_heading;
    in_ch.meas_heading = s.meas_heading;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_sample(s);
  endtask

  initial begin
    sample_t            s;
    logic signed [31:0] gx, gy, gz;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.goal_x = '0;
    in_ch.goal_y = '0;
    in_ch.goal_z = '0;
    in_ch.meas_x = '0;
    in_ch.meas_y = '0;
    in_ch.meas_z = '0;
    in_ch.goal_heading = '0;
    in_ch.meas_heading = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset gains: zero, saturating errors, heading extremes
    send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(pack_sample(POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MAX, 25736, -25736));
    send_sample(pack_sample(POS_MIN, 0, -65536, POS_MAX, POS_MIN, 65536, -25736, 25736));
    // headings at opposite extremes: the difference lies past pi and wraps by 2*pi once
    send_sample(pack_sample(1, -1, 65536, 0, 0, 0, 16'sh7FFF, 16'sh8000));
    send_sample(pack_sample(-1, 1, 0, 0, 0, 65536, 16'sh8000, 16'sh7FFF));
    s = pack_sample(32'h10000, -32'h8000, 3, 0, 32'h8000, -3, 100, -100);
    send_sample(s);
    send_sample(s);

    // every register at its top
    set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 31'h7FFFFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(pack_sample(POS_MAX, POS_MIN, 1000, POS_MIN, POS_MAX, -1000, 25736, -25736));
    send_sample(pack_sample(POS_MIN, POS_MAX, -1000, POS_MAX, POS_MIN, 1000, -25736, 25736));
    send_sample(pack_sample(5, -5, 0, 0, 0, 0, 1, -1));

    // every register at zero; writes past the register list change nothing
    set_config(24'd0, 24'd0, 24'd0, 31'd0, 16'd0, 16'd0);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom()));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom()));
    send_sample(pack_sample(POS_MAX, -65536, 12345, 0, 65536, -12345, 25000, -25000));
    send_sample(pack_sample(-7, 7, 0, 7, -7, 0, -3, 3));

    // zero dt and zero rate with live gains: no integral growth, no derivative
    set_config(24'd65536, 24'd1048576, 24'd1048576, 31'h7FFFFFFF, 16'd0, 16'd0);
    send_sample(pack_sample(32'h40000, -32'h40000, 32'h1000, 0, 0, 0, 8192, 0));
    send_sample(pack_sample(32'h80000, 32'h20000, -32'h1000, 0, 0, 0, 0, 8192));
    send_sample(pack_sample(-32'h80000, 0, 32'h7000000, 0, 0, 0, -20000, 20000));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          src_idle_pct = 26;
          snk_idle_pct = 81;
        end
        1: begin
          src_idle_pct = 81;
          snk_idle_pct = 26;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      if (phase == 0)
        set_config(RST_GAIN_PROP, RST_GAIN_INTEG, RST_GAIN_DERIV, RST_INTEG_CLAMP,
                   RST_STEP_TIME, RST_STEP_RATE);
      else
        set_config(rand_gain(), rand_gain(), rand_gain(),
                   ($urandom_range(4) == 0) ? 31'h7FFFFFFF : 31'($urandom_range(0, 4194304)),
                   rand_period(), rand_period());
      // long sink stall with the source still offering, so the input backs up
      if (phase == 5) hold_req = 1'b1;
      repeat (92) begin
        gx = rand_goal();
        gy = rand_goal();
        gz = rand_goal();
        send_sample(pack_sample(gx, gy, gz, rand_meas(gx), rand_meas(gy), rand_meas(gz),
                                rand_heading(), rand_heading()));
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.n_fail == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tpid_pkg.sv
rtl/tpid_if.sv
rtl/tpid_ctrl.sv
rtl/tpid_datapath.sv
rtl/three_axis_pid_with_yaw_hold.sv
tb/sv/tpid_sb_pkg.sv
tb/sv/tb_three_axis_pid_with_yaw_hold.sv
